/* src/heartbeat_membership_table_unit_assert.svh */
// Assertion macros for the heartbeat membership table unit.
// Needs a clock named i_clk and an active-low reset named i_rst_n in the including scope.
`ifndef HEARTBEAT_MEMBERSHIP_TABLE_UNIT_ASSERT_SVH
`define HEARTBEAT_MEMBERSHIP_TABLE_UNIT_ASSERT_SVH

// Condition in the same cycle.
`define HMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in the cycle after the antecedent.
`define HMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hmt_pkg.sv */
// Shared types, codes and helpers of the heartbeat membership table unit.
// No dependencies.
package hmt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_GOSSIP = 2'd1;
    localparam logic [1:0] CMD_JOIN_REQ = 2'd2;
    localparam logic [1:0] CMD_JOIN_REP = 2'd3;

    localparam logic [2:0] ST_SELF = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_UPDATED = 3'd2;
    localparam logic [2:0] ST_NO_CHANGE = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_TICK_DONE = 3'd5;

    localparam logic [2:0] REG_FAIL_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_CLEANUP_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_GOSSIP_PERIOD = 3'd2;
    localparam logic [2:0] REG_SELF_ID = 3'd3;
    localparam logic [2:0] REG_SELF_PORT = 3'd4;
    localparam logic [2:0] REG_IS_INTRODUCER = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] member_id;
        logic [15:0] member_port;
        logic [31:0] member_heartbeat;
        logic        last_entry;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  member_count;
        logic [31:0] own_heartbeat;
        logic [5:0]  removed_count;
        logic        gossip_due;
        logic [5:0]  active_count;
        logic        send_join_reply;
        logic        in_group;
    } t_out_word;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] heartbeat;
        logic [31:0] stamp;
    } t_entry;

    // Clamp an internal count to the six-bit result fields.
    function automatic logic [5:0] sat_count(input logic [CNT_W-1:0] n);
        logic [CNT_W+5:0] x;
        x = {6'd0, n};
        if (x > (CNT_W + 6)'(63)) begin
            return 6'd63;
        end
        return x[5:0];
    endfunction

endpackage

/* src/hmt_entry_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module hmt_entry_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 112
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/heartbeat_membership_table_unit.sv */
// Top level of the heartbeat membership table unit: configuration, sweep sequencer, results.
// Depends on hmt_pkg, hmt_entry_ram and heartbeat_membership_table_unit_assert.svh.
//
// Each command word runs through the sweep, drain and done states before the result strobe:
// the sequencer reads the peer slots one through 31 from the single read port of the entry
// RAM, one per cycle, uses the drain state for the last read data and the done state for the
// write-back and the result. The result appears on o_out for exactly one cycle with o_strobe
// high, and the receiver cannot stall it. busy is high from the accepting edge until the cycle
// of the strobe; a new word may be started in the strobe cycle. Slot zero, this node's own
// entry, lives in registers: its id and port are the self_id and self_port registers and its
// heartbeat is the own heartbeat. Peer valid bits are flip-flops cleared by reset, so the
// entry RAM needs no clearing pass. Configuration writes are taken in any cycle, but are
// meant for idle periods only.
module heartbeat_membership_table_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  hmt_pkg::t_in_word i_in,
    output logic              o_strobe,
    output hmt_pkg::t_out_word o_out,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam int EW = $bits(hmt_pkg::t_entry);
    localparam logic [hmt_pkg::IDX_W-1:0] LAST_IDX = hmt_pkg::IDX_W'(hmt_pkg::TABLE_DEPTH - 1);

    // Configuration registers.
    logic [15:0] r_fail_timeout;
    logic [15:0] r_cleanup_timeout;
    logic [15:0] r_gossip_period;
    logic [31:0] r_self_id;
    logic [15:0] r_self_port;

    // Node state.
    logic [31:0] r_time;
    logic [31:0] r_hb_self;
    logic [15:0] r_countdown;
    logic        r_group;
    logic [hmt_pkg::CNT_W-1:0] r_count;
    logic [hmt_pkg::TABLE_DEPTH-1:1] r_valid;

    // Sequencer.
    logic [1:0] r_state;
    logic [1:0] n_state;
    hmt_pkg::t_in_word r_in;
    logic [hmt_pkg::IDX_W-1:0] r_idx;
    logic [hmt_pkg::IDX_W-1:0] r_rd_idx;
    logic r_rd_vld;

    // Sweep findings.
    logic r_hit;
    logic [hmt_pkg::IDX_W-1:0] r_hit_idx;
    logic [31:0] r_hit_hb;
    logic r_hit_alive;
    logic r_free;
    logic [hmt_pkg::IDX_W-1:0] r_free_idx;
    logic [hmt_pkg::CNT_W-1:0] r_removed;
    logic [hmt_pkg::CNT_W-1:0] r_active;

    logic r_strobe;
    hmt_pkg::t_out_word r_out;
    hmt_pkg::t_out_word n_out;

    hmt_pkg::t_entry rd_entry;
    hmt_pkg::t_entry wr_entry;
    logic [EW-1:0] rd_bits;
    logic ram_we;
    logic [hmt_pkg::IDX_W-1:0] ram_waddr;
    logic [31:0] rd_age;
    logic rd_live;
    logic accept;
    logic is_self;
    logic [31:0] hb_bumped;

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign rd_entry = hmt_pkg::t_entry'(rd_bits);
    assign rd_age = r_time - rd_entry.stamp;
    assign rd_live = r_rd_vld && r_valid[r_rd_idx];
    assign is_self = (r_in.member_id == r_self_id) && (r_in.member_port == r_self_port);
    assign hb_bumped = (r_hb_self == 32'hFFFF_FFFF) ? r_hb_self : r_hb_self + 32'd1;

    // Inserts and refreshes write the same fields: id, port, heartbeat and current time.
    assign wr_entry = '{id: r_in.member_id, port: r_in.member_port,
                        heartbeat: r_in.member_heartbeat, stamp: r_time};

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_free_idx;
        if (r_state == S_DONE && r_in.cmd != hmt_pkg::CMD_TICK && !is_self) begin
            if (r_hit) begin
                ram_waddr = r_hit_idx;
                ram_we = (r_in.cmd == hmt_pkg::CMD_GOSSIP) && r_hit_alive
                         && (r_in.member_heartbeat > r_hit_hb);
            end else begin
                ram_we = r_free;
            end
        end
    end

    hmt_entry_ram #(
        .DEPTH(hmt_pkg::TABLE_DEPTH),
        .WIDTH(EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (r_state == S_SWEEP),
        .i_raddr (r_idx),
        .o_rdata (rd_bits)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_vld <= (r_state == S_SWEEP);
            r_strobe <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (accept) begin
            r_in <= i_in;
            r_idx <= hmt_pkg::IDX_W'(1);
        end else if (r_state == S_SWEEP && r_idx != LAST_IDX) begin
            r_idx <= r_idx + hmt_pkg::IDX_W'(1);
        end
    end

    // Gather the lookup match, the lowest free slot and the tick counts as slots stream by.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit <= 1'b0;
            r_free <= 1'b0;
            r_removed <= '0;
            r_active <= '0;
        end else if (r_rd_vld) begin
            if (rd_live && !r_hit && rd_entry.id == r_in.member_id
                && rd_entry.port == r_in.member_port) begin
                r_hit <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_hb <= rd_entry.heartbeat;
                r_hit_alive <= (rd_age <= {16'd0, r_fail_timeout});
            end
            if (!r_valid[r_rd_idx] && !r_free) begin
                r_free <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (rd_live && rd_age > {16'd0, r_cleanup_timeout}) begin
                r_removed <= hmt_pkg::CNT_W'(r_removed + 1'b1);
            end else if (rd_live && rd_age <= {16'd0, r_fail_timeout}) begin
                r_active <= hmt_pkg::CNT_W'(r_active + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_timeout <= 16'd5;
            r_cleanup_timeout <= 16'd20;
            r_gossip_period <= 16'd2;
            r_self_id <= 32'd1;
            r_self_port <= 16'd0;
            r_time <= '0;
            r_hb_self <= '0;
            r_countdown <= 16'd2;
            r_group <= 1'b1;
            r_count <= hmt_pkg::CNT_W'(1);
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hmt_pkg::REG_FAIL_TIMEOUT: r_fail_timeout <= i_cfg_data[15:0];
                    hmt_pkg::REG_CLEANUP_TIMEOUT: r_cleanup_timeout <= i_cfg_data[15:0];
                    hmt_pkg::REG_GOSSIP_PERIOD: r_gossip_period <= i_cfg_data[15:0];
                    hmt_pkg::REG_SELF_ID: r_self_id <= i_cfg_data;
                    hmt_pkg::REG_SELF_PORT: r_self_port <= i_cfg_data[15:0];
                    hmt_pkg::REG_IS_INTRODUCER: r_group <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            // During a tick sweep, stale peers drop out one slot at a time.
            if (rd_live && r_in.cmd == hmt_pkg::CMD_TICK && r_group
                && rd_age > {16'd0, r_cleanup_timeout}) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
            if (r_state == S_DONE) begin
                unique case (r_in.cmd)
                    hmt_pkg::CMD_TICK: begin
                        if (r_group) begin
                            r_count <= r_count - r_removed;
                            if (r_countdown != 16'd0) begin
                                r_countdown <= r_countdown - 16'd1;
                            end else begin
                                r_hb_self <= hb_bumped;
                                r_countdown <= r_gossip_period;
                            end
                        end
                        r_time <= r_time + 32'd1;
                    end
                    default: begin
                        if (r_in.cmd == hmt_pkg::CMD_JOIN_REQ) begin
                            r_hb_self <= hb_bumped;
                        end
                        if (r_in.cmd == hmt_pkg::CMD_JOIN_REP) begin
                            r_group <= 1'b1;
                        end
                        if (!is_self && !r_hit && r_free) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_count <= hmt_pkg::CNT_W'(r_count + 1'b1);
                        end
                    end
                endcase
            end
        end
    end

    // Result word, built from the state as it stands after this command.
    always_comb begin
        n_out = '0;
        n_out.own_heartbeat = r_hb_self;
        n_out.member_count = hmt_pkg::sat_count(r_count);
        n_out.in_group = r_group;
        unique case (r_in.cmd)
            hmt_pkg::CMD_TICK: begin
                n_out.status = hmt_pkg::ST_TICK_DONE;
                if (r_group) begin
                    n_out.removed_count = hmt_pkg::sat_count(r_removed);
                    n_out.member_count = hmt_pkg::sat_count(r_count - r_removed);
                    if (r_countdown == 16'd0) begin
                        n_out.own_heartbeat = hb_bumped;
                        n_out.gossip_due = 1'b1;
                        // Slot zero is refreshed by the bump and always counts as active.
                        n_out.active_count =
                            hmt_pkg::sat_count(hmt_pkg::CNT_W'(r_active + 1'b1));
                    end
                end
            end
            default: begin
                if (r_in.cmd == hmt_pkg::CMD_JOIN_REQ) begin
                    n_out.own_heartbeat = hb_bumped;
                    n_out.send_join_reply = 1'b1;
                end
                if (r_in.cmd == hmt_pkg::CMD_JOIN_REP) begin
                    n_out.in_group = 1'b1;
                end
                if (is_self) begin
                    n_out.status = hmt_pkg::ST_SELF;
                end else if (r_hit) begin
                    n_out.status = ram_we ? hmt_pkg::ST_UPDATED : hmt_pkg::ST_NO_CHANGE;
                end else if (r_free) begin
                    n_out.status = hmt_pkg::ST_INSERTED;
                    n_out.member_count =
                        hmt_pkg::sat_count(hmt_pkg::CNT_W'(r_count + 1'b1));
                end else begin
                    n_out.status = hmt_pkg::ST_FULL;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_out = r_out;

    // The unit holds at least its own entry, so a result never reports an empty table.
`include "heartbeat_membership_table_unit_assert.svh"
    `HMT_ASSERT_NEXT(a_done_strobes, r_state == S_DONE, o_strobe && !busy, "result not strobed")
    `HMT_ASSERT_NEXT(a_start_busy, accept, busy && !o_strobe, "accepted word not busy")
    `HMT_ASSERT_NOW(a_count_nonzero, o_strobe, o_out.member_count != 6'd0, "empty table reported")
    `HMT_ASSERT_NOW(a_write_at_end, ram_we, r_state == S_DONE && !r_rd_vld, "early RAM write")

endmodule

/* dv/tb_heartbeat_membership_table_unit.sv */
// Self-checking testbench of the heartbeat membership table unit.
// Depends on hmt_pkg and the heartbeat_membership_table_unit RTL; nothing else.
// A scoreboard class predicts each result word from its own copy of the membership table.
module tb_heartbeat_membership_table_unit;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SIZE = 48;

    // Scoreboard: mirrors the table, configuration and timers of the block and keeps the
    // expected result words in order of acceptance.
    class membership_scoreboard;
        logic [15:0] fail_to, clean_to, period, my_port, countdown;
        logic [31:0] my_id, now, own_hb;
        logic        member;
        logic        valid [hmt_pkg::TABLE_DEPTH];
        logic [31:0] ids [hmt_pkg::TABLE_DEPTH];
        logic [15:0] ports [hmt_pkg::TABLE_DEPTH];
        logic [31:0] hbs [hmt_pkg::TABLE_DEPTH];
        logic [31:0] stamps [hmt_pkg::TABLE_DEPTH];
        hmt_pkg::t_out_word pending [$];
        int          mismatches, checked, rounds, full_hits, removals, updates;

        function new();
            fail_to = 16'd5;
            clean_to = 16'd20;
            period = 16'd2;
            my_id = 32'd1;
            my_port = 16'd0;
            member = 1'b1;
            for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++) begin
                valid[i] = 1'b0;
                ids[i] = '0;
                ports[i] = '0;
                hbs[i] = '0;
                stamps[i] = '0;
            end
            valid[0] = 1'b1;
            ids[0] = my_id;
            now = '0;
            own_hb = '0;
            countdown = period;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                hmt_pkg::REG_FAIL_TIMEOUT: fail_to = data[15:0];
                hmt_pkg::REG_CLEANUP_TIMEOUT: clean_to = data[15:0];
                hmt_pkg::REG_GOSSIP_PERIOD: period = data[15:0];
                hmt_pkg::REG_SELF_ID: begin
                    my_id = data;
                    ids[0] = data;
                end
                hmt_pkg::REG_SELF_PORT: begin
                    my_port = data[15:0];
                    ports[0] = data[15:0];
                end
                hmt_pkg::REG_IS_INTRODUCER: member = data[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] age(int i);
            return now - stamps[i];
        endfunction

        function void bump_own();
            if (own_hb != 32'hFFFF_FFFF) begin
                own_hb = own_hb + 1;
            end
            valid[0] = 1'b1;
            hbs[0] = own_hb;
            stamps[0] = now;
        endfunction

        function int find_slot(logic [31:0] id, logic [15:0] port);
            for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++) begin
                if (valid[i] && ids[i] == id && ports[i] == port) return i;
            end
            return -1;
        endfunction

        function logic [2:0] add_peer(logic [31:0] id, logic [15:0] port, logic [31:0] hb);
            for (int i = 1; i < hmt_pkg::TABLE_DEPTH; i++) begin
                if (!valid[i]) begin
                    valid[i] = 1'b1;
                    ids[i] = id;
                    ports[i] = port;
                    hbs[i] = hb;
                    stamps[i] = now;
                    return hmt_pkg::ST_INSERTED;
                end
            end
            full_hits++;
            return hmt_pkg::ST_FULL;
        endfunction

        // Work out the result word caused by one accepted command word.
        function void note_input(hmt_pkg::t_in_word w);
            hmt_pkg::t_out_word exp_w;
            logic      is_self;
            int        slot, n;
            exp_w = '0;
            exp_w.status = hmt_pkg::ST_NO_CHANGE;
            is_self = (w.member_id == my_id) && (w.member_port == my_port);
            if (w.cmd == hmt_pkg::CMD_TICK) begin
                exp_w.status = hmt_pkg::ST_TICK_DONE;
                if (member) begin
                    for (int i = 1; i < hmt_pkg::TABLE_DEPTH; i++) begin
                        if (valid[i] && age(i) > {16'd0, clean_to}) begin
                            valid[i] = 1'b0;
                            exp_w.removed_count++;
                            removals++;
                        end
                    end
                    if (countdown > 0) begin
                        countdown--;
                    end else begin
                        bump_own();
                        n = 0;
                        for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++) begin
                            if (valid[i] && age(i) <= {16'd0, fail_to}) n++;
                        end
                        exp_w.gossip_due = 1'b1;
                        exp_w.active_count = 6'(n);
                        countdown = period;
                        rounds++;
                    end
                end
                now = now + 1;
            end else if (w.cmd == hmt_pkg::CMD_GOSSIP) begin
                if (is_self) begin
                    exp_w.status = hmt_pkg::ST_SELF;
                end else begin
                    slot = find_slot(w.member_id, w.member_port);
                    if (slot < 0) begin
                        exp_w.status = add_peer(w.member_id, w.member_port, w.member_heartbeat);
                    end else if (age(slot) <= {16'd0, fail_to}
                                 && w.member_heartbeat > hbs[slot]) begin
                        hbs[slot] = w.member_heartbeat;
                        stamps[slot] = now;
                        exp_w.status = hmt_pkg::ST_UPDATED;
                        updates++;
                    end
                end
            end else begin
                if (w.cmd == hmt_pkg::CMD_JOIN_REQ) begin
                    bump_own();
                    exp_w.send_join_reply = 1'b1;
                end else begin
                    member = 1'b1;
                end
                if (is_self) exp_w.status = hmt_pkg::ST_SELF;
                else if (find_slot(w.member_id, w.member_port) < 0)
                    exp_w.status = add_peer(w.member_id, w.member_port, w.member_heartbeat);
            end
            n = 0;
            for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++) begin
                if (valid[i]) n++;
            end
            exp_w.member_count = 6'(n);
            exp_w.own_heartbeat = own_hb;
            exp_w.in_group = member;
            pending = {pending, exp_w};
        endfunction

        function void report(string what, hmt_pkg::t_out_word e, hmt_pkg::t_out_word a);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %0d (%s): expected %p, got %p", mismatches, what, e, a);
            end
        endfunction

        // Compare one result word with the oldest expectation, field by field.
        function void check_result(hmt_pkg::t_out_word a);
            hmt_pkg::t_out_word e;
            string     bad;
            if (pending.size() == 0) begin
                report("no word expected", '0, a);
                return;
            end
            e = pending.pop_front();
            checked++;
            bad = "";
            if (a.status !== e.status) bad = {bad, " status"};
            if (a.member_count !== e.member_count) bad = {bad, " member_count"};
            if (a.own_heartbeat !== e.own_heartbeat) bad = {bad, " own_heartbeat"};
            if (a.removed_count !== e.removed_count) bad = {bad, " removed_count"};
            if (a.gossip_due !== e.gossip_due) bad = {bad, " gossip_due"};
            if (a.active_count !== e.active_count) bad = {bad, " active_count"};
            if (a.send_join_reply !== e.send_join_reply) bad = {bad, " send_join_reply"};
            if (a.in_group !== e.in_group) bad = {bad, " in_group"};
            if (bad != "") report(bad, e, a);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    hmt_pkg::t_in_word  i_in;
    logic        o_strobe;
    hmt_pkg::t_out_word o_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    membership_scoreboard board;
    int cycles;
    int sent;
    bit no_gaps;

    heartbeat_membership_table_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_in(i_in),
        .o_strobe(o_strobe),
        .o_out(o_out),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver cannot hold results off, so every strobe is checked at the edge
    // that ends its cycle. Values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result(o_out);
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_heartbeat_membership_table_unit: FAIL");
            $finish;
        end
    end

    // Present one command word and hold start until the block takes it. start is left
    // high so that a back-to-back word follows without a drop.
    task automatic send_word(hmt_pkg::t_in_word w);
        start <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (busy);
        board.note_input(w);
        sent++;
    endtask

    // Idle gap after a word: mostly none or short, now and then long.
    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue(logic [1:0] cmd, logic [31:0] id, logic [15:0] port,
                         logic [31:0] hb);
        hmt_pkg::t_in_word w;
        w.cmd = cmd;
        w.member_id = id;
        w.member_port = port;
        w.member_heartbeat = hb;
        w.last_entry = 1'($urandom_range(0, 1));
        send_word(w);
        idle_gap();
    endtask

    // Let every outstanding word come back, plus a margin for the sweep, before a
    // register write.
    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One register write; the caller drops the write enable after the last one.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Random traffic: a pool of peers that fills and refreshes the table, the own id
    // now and then, and fully random peers so that every field bit toggles.
    task automatic random_phase(int count);
        logic [1:0]  cmd;
        logic [31:0] id, hb;
        logic [15:0] port;
        int          r, k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30) cmd = hmt_pkg::CMD_TICK;
            else if (r < 75) cmd = hmt_pkg::CMD_GOSSIP;
            else if (r < 87) cmd = hmt_pkg::CMD_JOIN_REQ;
            else cmd = hmt_pkg::CMD_JOIN_REP;
            r = $urandom_range(0, 99);
            k = $urandom_range(0, POOL_SIZE - 1);
            if (r < 10) begin
                id = board.my_id;
                port = board.my_port;
            end else if (r < 80) begin
                id = 32'd100 + k;
                port = 16'(k % 3);
            end else begin
                id = $urandom;
                port = 16'($urandom);
            end
            if ($urandom_range(0, 1)) hb = $urandom;
            else hb = 32'(sent) + $urandom_range(0, 7);
            issue(cmd, id, port, hb);
        end
    endtask

    task automatic set_config(logic [15:0] fto, logic [15:0] cto, logic [15:0] per,
                              logic [31:0] sid, logic [15:0] sport, logic intro);
        drain();
        write_reg(hmt_pkg::REG_FAIL_TIMEOUT, {16'd0, fto});
        write_reg(hmt_pkg::REG_CLEANUP_TIMEOUT, {16'd0, cto});
        write_reg(hmt_pkg::REG_GOSSIP_PERIOD, {16'd0, per});
        write_reg(hmt_pkg::REG_SELF_ID, sid);
        write_reg(hmt_pkg::REG_SELF_PORT, {16'd0, sport});
        write_reg(hmt_pkg::REG_IS_INTRODUCER, {31'd0, intro});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        board = new();
        cycles = 0;
        sent = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset configuration.
        issue(hmt_pkg::CMD_TICK, '0, '0, '0);
        issue(hmt_pkg::CMD_GOSSIP, 32'd1, 16'd0, 32'hFFFF_FFFF);          // own entry is ignored
        issue(hmt_pkg::CMD_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'd10);       // unknown peer inserted
        issue(hmt_pkg::CMD_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF); // fresh and higher
        issue(hmt_pkg::CMD_GOSSIP, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);        // lower heartbeat
        issue(hmt_pkg::CMD_GOSSIP, 32'hFFFF_FFFF, 16'd0, 32'd0);           // same id, other port
        issue(hmt_pkg::CMD_GOSSIP, 32'd0, 16'hFFFF, 32'd5);
        issue(hmt_pkg::CMD_JOIN_REQ, 32'd7, 16'd7, 32'd3);                 // new sender added
        issue(hmt_pkg::CMD_JOIN_REQ, 32'd7, 16'd7, 32'd9);                 // sender already there
        issue(hmt_pkg::CMD_JOIN_REQ, 32'd1, 16'd0, 32'd0);                 // join from itself
        issue(hmt_pkg::CMD_JOIN_REP, 32'd8, 16'd8, 32'd1);
        issue(hmt_pkg::CMD_JOIN_REP, 32'd1, 16'd0, 32'd1);
        repeat (8) issue(hmt_pkg::CMD_TICK, '0, '0, '0);          // peers age past fail timeout
        issue(hmt_pkg::CMD_GOSSIP, 32'd0, 16'hFFFF, 32'd99);      // stale peer is not refreshed
        repeat (4) issue(hmt_pkg::CMD_TICK, '0, '0, '0);

        // Out of group: ticks only advance time, a join reply brings the node in.
        set_config(16'd3, 16'd6, 16'd1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        random_phase(190);
        set_config(16'd0, 16'd0, 16'd0, 32'd0, 16'd0, 1'b1);
        random_phase(190);
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd1, 16'd0, 1'b1);
        no_gaps = 1'b1;
        random_phase(190);                                        // table fills up
        no_gaps = 1'b0;
        set_config(16'd2, 16'd4, 16'd3, 32'd101, 16'd1, 1'b1);   // own id inside the pool
        random_phase(190);
        set_config(16'd10, 16'd30, 16'd5, 32'h8000_0000, 16'h8000, 1'b0);
        random_phase(190);
        set_config(16'd5, 16'd20, 16'd2, 32'd1, 16'd0, 1'b1);
        random_phase(190);
        set_config(16'd1, 16'd2, 16'd0, 32'h5A5A_A5A5, 16'hA5A5, 1'b1);
        random_phase(190);
        set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                   16'($urandom_range(0, 6)), $urandom, 16'($urandom), 1'b1);
        random_phase(190);

        drain();
        $display("%0d words sent, %0d results checked; %0d gossip rounds, %0d updates,",
                 sent, board.checked, board.rounds, board.updates);
        $display("%0d cleanup removals and %0d full-table refusals seen",
                 board.removals, board.full_hits);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tb_heartbeat_membership_table_unit: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                     board.pending.size());
            $display("tb_heartbeat_membership_table_unit: FAIL");
        end
        $finish;
    end

endmodule
